FILE: rtl/dtza_pkg.sv
// ----------------------------------------------------------------------------
// dtza_pkg
// Shared widths, constants, types and the month length lookup for the
// date/time zone adjust pipeline.
// ----------------------------------------------------------------------------
package dtza_pkg;

   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int YEAR_W  = 14;
   localparam int MON_W   = 4;
   localparam int DAY_W   = 5;
   localparam int TZ_W    = 11;
   localparam int FIELD_W = HOUR_W + MIN_W + YEAR_W + MON_W + DAY_W;
   localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;

   // biased minute sum: minute + offset + 18*60 is never negative
   localparam int SUM_W            = 12;
   localparam logic [SUM_W-1:0] MIN_BIAS = SUM_W'(1080);
   localparam int QUO_W            = 6;
   localparam int RECIP60          = 2185;
   localparam int SHIFT60          = 17;
   localparam int PROD60_W         = 24;
   // hour + q + 24 with q biased by 18
   localparam logic [6:0] HOUR_BIAS = 7'd6;

   localparam int RECIP25  = 10486;
   localparam int SHIFT25  = 18;
   localparam int PROD25_W = 28;
   localparam int Q25_W    = 9;

   localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);
   localparam logic [TZ_W-1:0]   TZ_RESET = '0;

   localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
   localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
   localparam logic [MON_W-1:0] MON_APR = MON_W'(4);
   localparam logic [MON_W-1:0] MON_JUN = MON_W'(6);
   localparam logic [MON_W-1:0] MON_SEP = MON_W'(9);
   localparam logic [MON_W-1:0] MON_NOV = MON_W'(11);
   localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

   typedef enum logic [1:0] {
      DAY_HOLD = 2'b00,
      DAY_BACK = 2'b01,
      DAY_FWD  = 2'b10
   } day_move_type;

   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
   } pipe_ctl_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m) inside
         MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAY_W'(30);
         MON_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
         default: len = DAY_W'(31);
      endcase
      return len;
   endfunction

endpackage

FILE: rtl/dtza_carry.sv
// ----------------------------------------------------------------------------
// dtza_carry
// Two-stage minute/hour arithmetic: adds the zone offset, floor-divides by 60
// and 24, and reports which way the day moves.
// ----------------------------------------------------------------------------
module dtza_carry (
   input  logic                          clock,
   input  dtza_pkg::pipe_ctl_type        ctl,
   input  logic [dtza_pkg::HOUR_W-1:0]   hour_in,
   input  logic [dtza_pkg::MIN_W-1:0]    minute_in,
   input  logic [dtza_pkg::TZ_W-1:0]     tz_offset,
   output logic [dtza_pkg::HOUR_W-1:0]   hour_out,
   output logic [dtza_pkg::MIN_W-1:0]    minute_out,
   output dtza_pkg::day_move_type        move_out
);
   import dtza_pkg::*;

   logic [SUM_W-1:0]    sum_in, sum_ff;
   logic [PROD60_W-1:0] prod60;
   logic [QUO_W-1:0]    quo_in, quo_ff;
   logic [HOUR_W-1:0]   hour1_in, hour1_ff;

   logic [SUM_W-1:0]    rem_full;
   logic [6:0]          hh;
   logic [6:0]          hr_full;
   logic [MIN_W-1:0]    min2_in, min2_ff;
   logic [HOUR_W-1:0]   hour2_in, hour2_ff;
   day_move_type        move2_in, move2_ff;

   // stage 1: biased minute sum and quotient by reciprocal multiply
   always_comb begin
      sum_in   = SUM_W'(minute_in) + {{(SUM_W-TZ_W){tz_offset[TZ_W-1]}}, tz_offset}
                 + MIN_BIAS;
      prod60   = PROD60_W'(sum_in) * PROD60_W'(RECIP60);
      quo_in   = prod60[SHIFT60 +: QUO_W];
      hour1_in = hour_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.ld1) begin
         sum_ff   <= sum_in;
         quo_ff   <= quo_in;
         hour1_ff <= hour1_in;
      end
   end

   // stage 2: minute remainder, hour wrap and day direction
   always_comb begin
      rem_full = sum_ff - SUM_W'(quo_ff) * SUM_W'(60);
      min2_in  = rem_full[MIN_W-1:0];
      hh       = 7'(hour1_ff) + 7'(quo_ff) + HOUR_BIAS;
      if (hh < 7'd24) begin
         hr_full  = hh;
         move2_in = DAY_BACK;
      end else if (hh < 7'd48) begin
         hr_full  = hh - 7'd24;
         move2_in = DAY_HOLD;
      end else if (hh < 7'd72) begin
         hr_full  = hh - 7'd48;
         move2_in = DAY_FWD;
      end else begin
         // carry past two days still moves the date by one
         hr_full  = hh - 7'd72;
         move2_in = DAY_FWD;
      end
      hour2_in = hr_full[HOUR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.ld2) begin
         min2_ff  <= min2_in;
         hour2_ff <= hour2_in;
         move2_ff <= move2_in;
      end
   end

   assign hour_out   = hour2_ff;
   assign minute_out = min2_ff;
   assign move_out   = move2_ff;

endmodule

FILE: rtl/dtza_year_chk.sv
// ----------------------------------------------------------------------------
// dtza_year_chk
// Two-stage year saturation and Gregorian leap test; carries month and day
// along to line up with the time arithmetic.
// ----------------------------------------------------------------------------
module dtza_year_chk (
   input  logic                          clock,
   input  dtza_pkg::pipe_ctl_type        ctl,
   input  logic [dtza_pkg::YEAR_W-1:0]   year_in,
   input  logic [dtza_pkg::MON_W-1:0]    month_in,
   input  logic [dtza_pkg::DAY_W-1:0]    day_in,
   output logic [dtza_pkg::YEAR_W-1:0]   year_out,
   output logic [dtza_pkg::MON_W-1:0]    month_out,
   output logic [dtza_pkg::DAY_W-1:0]    day_out,
   output logic                          leap_out
);
   import dtza_pkg::*;

   logic [YEAR_W-1:0]   ysat_in, year1_ff, year2_ff;
   logic [PROD25_W-1:0] prod25;
   logic [Q25_W-1:0]    q25_in, q25_ff;
   logic [MON_W-1:0]    mon1_ff, mon2_ff;
   logic [DAY_W-1:0]    day1_ff, day2_ff;
   logic [YEAR_W-1:0]   back25;
   logic                div25;
   logic                leap_in, leap_ff;

   always_comb begin
      ysat_in = (year_in > YEAR_MAX) ? YEAR_MAX : year_in;
      prod25  = PROD25_W'(ysat_in) * PROD25_W'(RECIP25);
      q25_in  = prod25[SHIFT25 +: Q25_W];
   end

   always_ff @(posedge clock) begin
      if (ctl.ld1) begin
         year1_ff <= ysat_in;
         q25_ff   <= q25_in;
         mon1_ff  <= month_in;
         day1_ff  <= day_in;
      end
   end

   // divisible by 100 is divisible by 4 and 25; by 400 adds divisible by 16
   always_comb begin
      back25  = YEAR_W'(q25_ff) * YEAR_W'(25);
      div25   = (back25 == year1_ff);
      leap_in = (year1_ff[1:0] == 2'b00) && (!div25 || (year1_ff[3:0] == 4'b0000));
   end

   always_ff @(posedge clock) begin
      if (ctl.ld2) begin
         year2_ff <= year1_ff;
         mon2_ff  <= mon1_ff;
         day2_ff  <= day1_ff;
         leap_ff  <= leap_in;
      end
   end

   assign year_out  = year2_ff;
   assign month_out = mon2_ff;
   assign day_out   = day2_ff;
   assign leap_out  = leap_ff;

endmodule

FILE: rtl/dtza_roll.sv
// ----------------------------------------------------------------------------
// dtza_roll
// Final stage: moves the date one day back or forward across month and year
// ends and registers the complete result word.
// ----------------------------------------------------------------------------
module dtza_roll (
   input  logic                          clock,
   input  dtza_pkg::pipe_ctl_type        ctl,
   input  dtza_pkg::day_move_type        move_in,
   input  logic                          leap_in,
   input  logic [dtza_pkg::HOUR_W-1:0]   hour_in,
   input  logic [dtza_pkg::MIN_W-1:0]    minute_in,
   input  logic [dtza_pkg::YEAR_W-1:0]   year_in,
   input  logic [dtza_pkg::MON_W-1:0]    month_in,
   input  logic [dtza_pkg::DAY_W-1:0]    day_in,
   output logic [dtza_pkg::HOUR_W-1:0]   hour_out,
   output logic [dtza_pkg::MIN_W-1:0]    minute_out,
   output logic [dtza_pkg::YEAR_W-1:0]   year_out,
   output logic [dtza_pkg::MON_W-1:0]    month_out,
   output logic [dtza_pkg::DAY_W-1:0]    day_out
);
   import dtza_pkg::*;

   logic [YEAR_W-1:0] year_nx, year_ff;
   logic [MON_W-1:0]  mon_nx, mon_ff;
   logic [DAY_W-1:0]  day_nx, day_ff;
   logic [HOUR_W-1:0] hour_ff;
   logic [MIN_W-1:0]  min_ff;

   always_comb begin
      year_nx = year_in;
      mon_nx  = month_in;
      day_nx  = day_in;
      case (move_in)
         DAY_BACK: begin
            if (day_in <= DAY_W'(1)) begin
               if (month_in <= MON_JAN) begin
                  mon_nx = MON_DEC;
                  if (year_in != '0) begin
                     year_nx = year_in - YEAR_W'(1);
                  end
               end else if (month_in > MON_DEC) begin
                  mon_nx = MON_DEC;
               end else begin
                  mon_nx = month_in - MON_W'(1);
               end
               // the leap flag only matters for february, whose year is unchanged
               day_nx = month_len(mon_nx, leap_in);
            end else begin
               day_nx = day_in - DAY_W'(1);
            end
         end
         DAY_FWD: begin
            if (day_in >= month_len(month_in, leap_in)) begin
               day_nx = DAY_W'(1);
               if (month_in >= MON_DEC) begin
                  mon_nx = MON_JAN;
                  if (year_in < YEAR_MAX) begin
                     year_nx = year_in + YEAR_W'(1);
                  end
               end else begin
                  mon_nx = month_in + MON_W'(1);
               end
            end else begin
               day_nx = day_in + DAY_W'(1);
            end
         end
         default: begin
            day_nx = day_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.ld3) begin
         hour_ff <= hour_in;
         min_ff  <= minute_in;
         year_ff <= year_nx;
         mon_ff  <= mon_nx;
         day_ff  <= day_nx;
      end
   end

   assign hour_out   = hour_ff;
   assign minute_out = min_ff;
   assign year_out   = year_ff;
   assign month_out  = mon_ff;
   assign day_out    = day_ff;

endmodule

FILE: rtl/date_time_zone_adjust_top.sv
// ----------------------------------------------------------------------------
// date_time_zone_adjust_top
// Shifts a UTC civil date and time by a programmable zone offset in minutes.
//
//   channel   direction  handshake        payload
//   req_      in         tvalid/tready    tdata: hour, minute, year, month, day
//   rsp_      out        tvalid/tready    tdata: hour, minute, year, month, day
//   csr_      in         wr_en            wr_data: signed offset in minutes
//
// Three register stages; one word is accepted every cycle unless a stalled
// output backs up the pipe. The depth is set by the reciprocal multiplies
// (minute by 60, year by 25) and the month/year roll stage.
// Reset clears the valid bits and sets the offset to zero.
// Each stage loads while it is empty or its word moves on, so bubbles fill up
// and a stalled output holds its word without losing or repeating one.
// ----------------------------------------------------------------------------
module date_time_zone_adjust_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [4:0] hour_in, [10:5] minute_in, [24:11] year_in, [28:25] month_in,
   // [33:29] day_in, [39:34] zero
   input  logic [dtza_pkg::TDATA_W-1:0]    req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [4:0] hour_out, [10:5] minute_out, [24:11] year_out, [28:25] month_out,
   // [33:29] day_out, [39:34] zero
   output logic [dtza_pkg::TDATA_W-1:0]    rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [dtza_pkg::TZ_W-1:0]       csr_wr_data
);
   import dtza_pkg::*;

   localparam int MIN_LO  = HOUR_W;
   localparam int YEAR_LO = MIN_LO + MIN_W;
   localparam int MON_LO  = YEAR_LO + YEAR_W;
   localparam int DAY_LO  = MON_LO + MON_W;

   logic [TZ_W-1:0] tz_ff;
   logic            v1_ff, v2_ff, v3_ff;
   pipe_ctl_type    ctl;

   logic [HOUR_W-1:0] c_hour;
   logic [MIN_W-1:0]  c_min;
   day_move_type      c_move;
   logic [YEAR_W-1:0] y_year;
   logic [MON_W-1:0]  y_mon;
   logic [DAY_W-1:0]  y_day;
   logic              y_leap;

   logic [HOUR_W-1:0] o_hour;
   logic [MIN_W-1:0]  o_min;
   logic [YEAR_W-1:0] o_year;
   logic [MON_W-1:0]  o_mon;
   logic [DAY_W-1:0]  o_day;

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_ff <= TZ_RESET;
      end else if (csr_wr_en) begin
         tz_ff <= csr_wr_data;
      end
   end

   // per-stage load: empty, or the word in it moves on this cycle
   always_comb begin
      ctl.ld3 = !v3_ff || rsp_tready;
      ctl.ld2 = !v2_ff || ctl.ld3;
      ctl.ld1 = !v1_ff || ctl.ld2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ctl.ld1) begin
            v1_ff <= req_tvalid;
         end
         if (ctl.ld2) begin
            v2_ff <= v1_ff;
         end
         if (ctl.ld3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   assign req_tready = ctl.ld1;
   assign rsp_tvalid = v3_ff;

   dtza_carry u_carry (
      .clock      (clock),
      .ctl        (ctl),
      .hour_in    (req_tdata[HOUR_W-1:0]),
      .minute_in  (req_tdata[MIN_LO +: MIN_W]),
      .tz_offset  (tz_ff),
      .hour_out   (c_hour),
      .minute_out (c_min),
      .move_out   (c_move)
   );

   dtza_year_chk u_year_chk (
      .clock     (clock),
      .ctl       (ctl),
      .year_in   (req_tdata[YEAR_LO +: YEAR_W]),
      .month_in  (req_tdata[MON_LO +: MON_W]),
      .day_in    (req_tdata[DAY_LO +: DAY_W]),
      .year_out  (y_year),
      .month_out (y_mon),
      .day_out   (y_day),
      .leap_out  (y_leap)
   );

   dtza_roll u_roll (
      .clock      (clock),
      .ctl        (ctl),
      .move_in    (c_move),
      .leap_in    (y_leap),
      .hour_in    (c_hour),
      .minute_in  (c_min),
      .year_in    (y_year),
      .month_in   (y_mon),
      .day_in     (y_day),
      .hour_out   (o_hour),
      .minute_out (o_min),
      .year_out   (o_year),
      .month_out  (o_mon),
      .day_out    (o_day)
   );

   assign rsp_tdata = {(TDATA_W - FIELD_W)'(0), o_day, o_mon, o_year, o_min, o_hour};

endmodule
